// File: rtl/heap_sort_engine_core_assert.svh
// Assertion macros for the sorting engine.
// Used by heap_sort_engine_core; expects clk and rst_n in scope.
`ifndef HEAP_SORT_ENGINE_CORE_ASSERT_SVH
`define HEAP_SORT_ENGINE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hse_pkg.sv
// Shared constants and types for the sorting engine.
// No dependencies; imported by hse_cell and heap_sort_engine_core.
package hse_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } hse_state_t;

endpackage

// File: rtl/hse_cell.sv
// One cell of the sorting chain: keeps the smaller value, passes the larger on.
// Depends on hse_pkg.
module hse_cell
    import hse_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [VALUE_WIDTH-1:0] in_value,
    output logic                   pass_valid,
    output logic [VALUE_WIDTH-1:0] pass_value,
    input  logic                   shift_en,
    input  logic                   shift_valid,
    input  logic [VALUE_WIDTH-1:0] shift_value,
    output logic                   held_valid,
    output logic [VALUE_WIDTH-1:0] held_value
);

    logic                   held_valid_reg;
    logic                   held_valid_next;
    logic [VALUE_WIDTH-1:0] held_value_reg;
    logic [VALUE_WIDTH-1:0] held_value_next;
    logic                   pass_valid_reg;
    logic                   pass_valid_next;
    logic [VALUE_WIDTH-1:0] pass_value_reg;
    logic [VALUE_WIDTH-1:0] pass_value_next;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_value_next = held_value_reg;
        pass_valid_next = 1'b0;
        pass_value_next = in_value;
        if (shift_en)
        begin
            held_valid_next = shift_valid;
            held_value_next = shift_value;
        end
        else if (in_valid)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next = 1'b1;
                held_value_next = in_value;
            end
            else if ($signed(in_value) < $signed(held_value_reg))
            begin
                held_value_next = in_value;
                pass_valid_next = 1'b1;
                pass_value_next = held_value_reg;
            end
            else
            begin
                pass_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_value_reg <= held_value_next;
        pass_value_reg <= pass_value_next;
    end

    assign held_valid = held_valid_reg;
    assign held_value = held_value_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_value = pass_value_reg;

endmodule

// File: rtl/heap_sort_engine_core.sv
// Top level of the sorting engine: input stage, chain of hse_cell and control.
// Depends on hse_pkg, hse_cell and heap_sort_engine_core_assert.svh.
//
// Values are loaded one per cycle while the block is in its load state, each
// request that finds room entering a chain of CAPACITY cells in which every
// value settles at its ordered place. The request marked last closes the set;
// the block then waits until the chain is still and streams the set out in
// ascending signed order at one result per cycle while the receiver is ready,
// the largest value marked last. Requests arriving with the store full are
// dropped, and every result of that set carries the overflow flag.
`include "heap_sort_engine_core_assert.svh"

module heap_sort_engine_core
    import hse_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_WIDTH-1:0] s_tdata,   // value, then zero padding
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_WIDTH-1:0] m_tdata,   // sorted_value, then zero padding
    output logic                   m_tlast,
    output logic                   m_tuser    // overflow
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    hse_state_t             state_reg;
    hse_state_t             state_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   dropped_reg;
    logic                   dropped_next;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [VALUE_WIDTH-1:0] in_value_reg;

    logic                   in_accept;
    logic                   out_accept;
    logic                   chain_busy;

    logic [CAPACITY:0]      chain_valid;
    logic [VALUE_WIDTH-1:0] chain_value [0:CAPACITY];
    logic [CAPACITY:0]      held_valid;
    logic [VALUE_WIDTH-1:0] held_value  [0:CAPACITY];

    assign s_tready   = (state_reg == ST_LOAD);
    assign in_accept  = s_tvalid && s_tready;
    assign m_tvalid   = (state_reg == ST_EMIT);
    assign out_accept = m_tvalid && m_tready;
    assign chain_busy = |chain_valid;

    assign chain_valid[0] = in_valid_reg;
    assign chain_value[0] = in_value_reg;
    assign held_valid[CAPACITY] = 1'b0;
    assign held_value[CAPACITY] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        hse_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (chain_valid[i]),
            .in_value   (chain_value[i]),
            .pass_valid (chain_valid[i+1]),
            .pass_value (chain_value[i+1]),
            .shift_en   (out_accept),
            .shift_valid(held_valid[i+1]),
            .shift_value(held_value[i+1]),
            .held_valid (held_valid[i]),
            .held_value (held_value[i])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        in_valid_next = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (count_reg < CNT_W'(CAPACITY))
                    begin
                        in_valid_next = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!chain_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_accept)
                begin
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dropped_reg  <= dropped_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_value_reg <= s_tdata[VALUE_WIDTH-1:0];
        end
    end

    assign m_tdata = TDATA_WIDTH'(held_value[0]);
    assign m_tlast = (count_reg == CNT_W'(1));
    assign m_tuser = dropped_reg;

    `HSE_ASSERT_SAME(a_emit_has_data, m_tvalid, held_valid[0] && (count_reg != '0), "result offered from an empty chain")
    `HSE_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "element count beyond capacity")
    `HSE_ASSERT_NEXT(a_last_closes, in_accept && s_tlast, state_reg == ST_DRAIN, "last request did not close the set")
    `HSE_ASSERT_SAME(a_emit_still, m_tvalid, !chain_busy, "chain still moving while results are offered")

endmodule
